>>> src/brake_angle_from_velocity_macros.svh
// ----------------------------------------------------------------------------
// Brake angle assertion macros
// Shared concurrent assertion helpers for the brake angle block.
// ----------------------------------------------------------------------------
`ifndef BRAKE_ANGLE_FROM_VELOCITY_MACROS_SVH
`define BRAKE_ANGLE_FROM_VELOCITY_MACROS_SVH

// Same-cycle implication.
`define BAFV_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("brake angle assertion failed");

// Next-cycle implication.
`define BAFV_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("brake angle assertion failed");

`endif

>>> src/bafv_pkg.sv
// ----------------------------------------------------------------------------
// Brake angle package
// Widths, constants, microcode and shared types of the brake angle block.
// ----------------------------------------------------------------------------
package bafv_pkg;

	localparam int NUM_AXES = 2;
	localparam int AX_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

	localparam int VEL_W = 13;
	localparam int MAG_W = 13;
	localparam int P_W = 26;
	localparam int GP_W = 42;
	localparam int SUM_W = 44;
	localparam int N_W = 28;
	localparam int Q_W = 16;
	localparam int CNT_W = 4;
	localparam int ANG_W = 17;
	localparam int SLEW_W = 18;
	localparam int GAIN_W = 16;
	localparam int RATE_W = 7;
	localparam int LIM_W = 14;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam int PC_W = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd2;

	localparam logic [GAIN_W-1:0] GAIN_RST = 16'd1409;
	localparam logic [RATE_W-1:0] RATE_RST = 7'd8;
	localparam logic [LIM_W-1:0] LIMIT_RST = 14'd3000;

	localparam logic [MAG_W-1:0] DEN_OFS = 13'd60;
	localparam logic [MAG_W-1:0] NUM_OFS = 13'd560;
	localparam logic [Q_W-1:0] ANGLE_SAT = 16'd36000;
	localparam logic [RATE_W-1:0] MIN_STEP = 7'd4;
	localparam logic [CNT_W-1:0] DIV_LAST = 4'd15;

	localparam logic [PC_W-1:0] PC_LOAD = 4'd0;
	localparam logic [PC_W-1:0] PC_DIV = 4'd5;

	typedef enum logic [3:0] {
		OP_LOAD,
		OP_MUL1,
		OP_MUL2,
		OP_BIAS,
		OP_CHK,
		OP_DIV,
		OP_LEAN,
		OP_SLEW,
		OP_STORE
	} op_t;

	typedef enum logic [1:0] {
		C_NEXT,
		C_WAIT_ITEM,
		C_LOOP_DIV,
		C_WAIT_OUT
	} cond_t;

	typedef struct packed {
		op_t op;
		cond_t cond;
		logic [PC_W-1:0] target;
	} uword_t;

	typedef struct packed {
		op_t op;
		logic en;
	} ctrl_t;

	typedef struct packed {
		logic item_valid;
		logic out_free;
		logic div_more;
	} stat_t;

	typedef struct packed {
		logic [GAIN_W-1:0] gain;
		logic [RATE_W-1:0] rate;
		logic [LIM_W-1:0] limit;
	} cfg_t;

	function automatic uword_t ucode(input logic [PC_W-1:0] pc);
		uword_t w;
		case (pc)
			4'd0: w = '{op: OP_LOAD, cond: C_WAIT_ITEM, target: PC_LOAD};
			4'd1: w = '{op: OP_MUL1, cond: C_NEXT, target: PC_LOAD};
			4'd2: w = '{op: OP_MUL2, cond: C_NEXT, target: PC_LOAD};
			4'd3: w = '{op: OP_BIAS, cond: C_NEXT, target: PC_LOAD};
			4'd4: w = '{op: OP_CHK, cond: C_NEXT, target: PC_LOAD};
			4'd5: w = '{op: OP_DIV, cond: C_LOOP_DIV, target: PC_DIV};
			4'd6: w = '{op: OP_LEAN, cond: C_NEXT, target: PC_LOAD};
			4'd7: w = '{op: OP_SLEW, cond: C_NEXT, target: PC_LOAD};
			4'd8: w = '{op: OP_STORE, cond: C_WAIT_OUT, target: PC_LOAD};
			default: w = '{op: OP_LOAD, cond: C_WAIT_ITEM, target: PC_LOAD};
		endcase
		return w;
	endfunction

	function automatic logic [AX_W-1:0] axis_index(input logic axis);
		logic [AX_W-1:0] idx;
		if (NUM_AXES == 1)
			idx = '0;
		else
			idx = AX_W'(axis);
		return idx;
	endfunction

endpackage

>>> src/bafv_seq.sv
// ----------------------------------------------------------------------------
// Brake angle sequencer
// Step counter over the microcode table with waits and the divider loop.
// ----------------------------------------------------------------------------
module bafv_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  bafv_pkg::stat_t  stat,
	output bafv_pkg::ctrl_t  ctrl
);

	logic [bafv_pkg::PC_W-1:0] pc_q;
	logic [bafv_pkg::PC_W-1:0] pc_d;
	bafv_pkg::uword_t uw;

	assign uw = bafv_pkg::ucode(pc_q);

	always_comb begin
		pc_d = pc_q;
		ctrl.op = uw.op;
		ctrl.en = 1'b1;
		case (uw.cond)
			bafv_pkg::C_NEXT: begin
				pc_d = pc_q + bafv_pkg::PC_W'(1);
			end
			bafv_pkg::C_WAIT_ITEM: begin
				ctrl.en = stat.item_valid;
				if (stat.item_valid)
					pc_d = pc_q + bafv_pkg::PC_W'(1);
			end
			bafv_pkg::C_LOOP_DIV: begin
				if (stat.div_more)
					pc_d = uw.target;
				else
					pc_d = pc_q + bafv_pkg::PC_W'(1);
			end
			bafv_pkg::C_WAIT_OUT: begin
				ctrl.en = stat.out_free;
				if (stat.out_free)
					pc_d = uw.target;
			end
			default: begin
				pc_d = bafv_pkg::PC_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pc_q <= bafv_pkg::PC_LOAD;
		else
			pc_q <= pc_d;
	end

endmodule

>>> src/bafv_dp.sv
// ----------------------------------------------------------------------------
// Brake angle datapath
// Multiplier, restoring divider, slew and clamp logic and the angle store.
// ----------------------------------------------------------------------------
module bafv_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bafv_pkg::ctrl_t                     ctrl,
	input  bafv_pkg::cfg_t                      cfg,
	input  logic                                axis,
	input  logic signed [bafv_pkg::VEL_W-1:0]   velocity,
	output logic                                div_more,
	output logic signed [bafv_pkg::ANG_W-1:0]   new_angle
);

	localparam int MW = bafv_pkg::MAG_W;
	localparam int SW = bafv_pkg::SLEW_W;

	logic [bafv_pkg::AX_W-1:0] ax_q;
	logic neg_q;
	logic [MW-1:0] mag_q;
	logic [MW-1:0] den_q;
	logic [bafv_pkg::P_W-1:0] p_q;
	logic [bafv_pkg::GP_W-1:0] gp_q;
	logic [bafv_pkg::N_W-1:0] n_q;
	logic [MW-1:0] rem_q;
	logic [bafv_pkg::Q_W-1:0] quo_q;
	logic [bafv_pkg::CNT_W-1:0] cnt_q;
	logic sat_q;
	logic signed [bafv_pkg::ANG_W-1:0] lean_q;
	logic signed [SW-1:0] slew_q;
	logic signed [bafv_pkg::ANG_W-1:0] angles_q [bafv_pkg::NUM_AXES];

	logic [MW-1:0] mag_in;
	logic [MW-1:0] mag_plus;
	logic [bafv_pkg::SUM_W-1:0] bias_sum;
	logic [MW:0] trial;
	logic trial_ge;
	logic [bafv_pkg::Q_W-1:0] mag_lean;
	logic [bafv_pkg::RATE_W-1:0] step;
	logic signed [SW-1:0] cur_x;
	logic signed [SW-1:0] step_x;
	logic signed [SW-1:0] lean_x;
	logic signed [SW-1:0] lo;
	logic signed [SW-1:0] hi;
	logic signed [SW-1:0] slew_d;
	logic [bafv_pkg::Q_W-1:0] lim4;
	logic [bafv_pkg::Q_W-1:0] lim;
	logic signed [SW-1:0] lim_x;
	logic signed [SW-1:0] clamp;
	logic fire;

	assign fire = ctrl.en;

	assign mag_in = velocity[bafv_pkg::VEL_W-1] ? MW'(-velocity) : MW'(velocity);
	assign mag_plus = mag_q + bafv_pkg::NUM_OFS;
	assign bias_sum = {gp_q, 2'b00} + (bafv_pkg::SUM_W'(den_q) << 15);

	assign trial = {rem_q, quo_q[bafv_pkg::Q_W-1]};
	assign trial_ge = trial >= {1'b0, den_q};
	assign div_more = cnt_q != '0;

	assign mag_lean = (sat_q || quo_q > bafv_pkg::ANGLE_SAT) ? bafv_pkg::ANGLE_SAT : quo_q;

	assign step = (cfg.rate < bafv_pkg::MIN_STEP) ? bafv_pkg::MIN_STEP : cfg.rate;
	assign cur_x = SW'(angles_q[ax_q]);
	assign step_x = $signed({{(SW - bafv_pkg::RATE_W){1'b0}}, step});
	assign lean_x = SW'(lean_q);
	assign lo = cur_x - step_x;
	assign hi = cur_x + step_x;

	always_comb begin
		if (lean_x < lo)
			slew_d = lo;
		else if (lean_x > hi)
			slew_d = hi;
		else
			slew_d = lean_x;
	end

	assign lim4 = {cfg.limit, 2'b00};
	assign lim = (lim4 > bafv_pkg::ANGLE_SAT) ? bafv_pkg::ANGLE_SAT : lim4;
	assign lim_x = $signed({{(SW - bafv_pkg::Q_W){1'b0}}, lim});

	always_comb begin
		if (slew_q < -lim_x)
			clamp = -lim_x;
		else if (slew_q > lim_x)
			clamp = lim_x;
		else
			clamp = slew_q;
	end

	assign new_angle = clamp[bafv_pkg::ANG_W-1:0];

	always_ff @(posedge clk) begin
		if (fire) begin
			case (ctrl.op)
				bafv_pkg::OP_LOAD: begin
					ax_q <= bafv_pkg::axis_index(axis);
					neg_q <= velocity[bafv_pkg::VEL_W-1];
					mag_q <= mag_in;
					den_q <= mag_in + bafv_pkg::DEN_OFS;
				end
				bafv_pkg::OP_MUL1: begin
					p_q <= bafv_pkg::P_W'(mag_q) * bafv_pkg::P_W'(mag_plus);
				end
				bafv_pkg::OP_MUL2: begin
					gp_q <= bafv_pkg::GP_W'(cfg.gain) * bafv_pkg::GP_W'(p_q);
				end
				bafv_pkg::OP_BIAS: begin
					n_q <= bias_sum[bafv_pkg::SUM_W-1:16];
				end
				bafv_pkg::OP_CHK: begin
					sat_q <= {1'b0, n_q[bafv_pkg::N_W-1:bafv_pkg::Q_W]} >= den_q;
					rem_q <= MW'(n_q[bafv_pkg::N_W-1:bafv_pkg::Q_W]);
					quo_q <= n_q[bafv_pkg::Q_W-1:0];
				end
				bafv_pkg::OP_DIV: begin
					rem_q <= trial_ge ? MW'(trial - {1'b0, den_q}) : trial[MW-1:0];
					quo_q <= {quo_q[bafv_pkg::Q_W-2:0], trial_ge};
				end
				bafv_pkg::OP_LEAN: begin
					if (neg_q)
						lean_q <= $signed({1'b0, mag_lean});
					else
						lean_q <= -$signed({1'b0, mag_lean});
				end
				bafv_pkg::OP_SLEW: begin
					slew_q <= slew_d;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			for (int i = 0; i < bafv_pkg::NUM_AXES; i++)
				angles_q[i] <= '0;
		end else if (fire) begin
			case (ctrl.op)
				bafv_pkg::OP_CHK: begin
					cnt_q <= bafv_pkg::DIV_LAST;
				end
				bafv_pkg::OP_DIV: begin
					if (cnt_q != '0)
						cnt_q <= cnt_q - bafv_pkg::CNT_W'(1);
				end
				bafv_pkg::OP_STORE: begin
					angles_q[ax_q] <= new_angle;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

>>> src/brake_angle_from_velocity.sv
// ----------------------------------------------------------------------------
// Brake angle from velocity
// Per-axis braking lean angle with slew and limit, microcoded datapath.
// ----------------------------------------------------------------------------
// A request carries an axis and a signed velocity in cm/s. It is taken when
// item_valid is high and item_stall is low. Each request yields one result,
// angle in quarter centidegrees, offered on result_valid and taken when
// result_stall is low.
// Registers are written on the cfg channel; cfg_ready is always high, and
// writes are expected only while the block is idle. An unused index is ignored.
// The result register is loaded by the store step of each request: the load
// step takes the request, then come two multiplies, the rounding bias and
// overflow check, sixteen steps of the restoring divider, then lean, slew and
// store. A new request is taken only after the store step of the previous one.
// The next request is accepted while a result still waits in the output
// register; if that result is still stalled when the next one is ready, the
// store step holds until it is taken.
// Reset clears both stored axis angles to zero, loads the register defaults
// and empties the output register.
// ----------------------------------------------------------------------------
`include "brake_angle_from_velocity_macros.svh"

module brake_angle_from_velocity (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     item_valid,
	output logic                                     item_stall,
	input  logic                                     axis,
	input  logic signed [bafv_pkg::VEL_W-1:0]        velocity,
	output logic                                     result_valid,
	input  logic                                     result_stall,
	output logic signed [bafv_pkg::ANG_W-1:0]        angle,
	input  logic                                     cfg_valid,
	output logic                                     cfg_ready,
	input  logic [bafv_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  logic [bafv_pkg::CFG_DATA_W-1:0]          cfg_data
);

	bafv_pkg::ctrl_t ctrl;
	bafv_pkg::stat_t stat;
	bafv_pkg::cfg_t cfg_q;
	logic div_more;
	logic signed [bafv_pkg::ANG_W-1:0] new_angle;
	logic result_valid_q;
	logic signed [bafv_pkg::ANG_W-1:0] angle_q;
	logic out_free;
	logic store_go;
	logic item_take;
	logic angle_ok;

	assign out_free = !result_valid_q || !result_stall;
	assign stat = '{item_valid: item_valid, out_free: out_free, div_more: div_more};
	assign store_go = (ctrl.op == bafv_pkg::OP_STORE) && ctrl.en;
	assign item_take = item_valid && !item_stall;
	assign angle_ok = (angle_q >= -$signed({1'b0, bafv_pkg::ANGLE_SAT}))
		&& (angle_q <= $signed({1'b0, bafv_pkg::ANGLE_SAT}));

	assign item_stall = ctrl.op != bafv_pkg::OP_LOAD;
	assign cfg_ready = 1'b1;
	assign result_valid = result_valid_q;
	assign angle = angle_q;

	bafv_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	bafv_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.cfg       (cfg_q),
		.axis      (axis),
		.velocity  (velocity),
		.div_more  (div_more),
		.new_angle (new_angle)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain <= bafv_pkg::GAIN_RST;
			cfg_q.rate <= bafv_pkg::RATE_RST;
			cfg_q.limit <= bafv_pkg::LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bafv_pkg::CFG_GAIN: cfg_q.gain <= cfg_data[bafv_pkg::GAIN_W-1:0];
				bafv_pkg::CFG_RATE: cfg_q.rate <= cfg_data[bafv_pkg::RATE_W-1:0];
				bafv_pkg::CFG_LIMIT: cfg_q.limit <= cfg_data[bafv_pkg::LIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid_q <= 1'b0;
		else if (store_go)
			result_valid_q <= 1'b1;
		else if (!result_stall)
			result_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (store_go)
			angle_q <= new_angle;
	end

	`BAFV_ASSERT_NEXT(a_accept_starts_mul, clk, arst_n, item_take, ctrl.op == bafv_pkg::OP_MUL1)
	`BAFV_ASSERT_IMPL(a_store_needs_room, clk, arst_n, store_go, out_free)
	`BAFV_ASSERT_NEXT(a_store_shows_result, clk, arst_n, store_go, result_valid_q)
	`BAFV_ASSERT_IMPL(a_result_in_range, clk, arst_n, result_valid_q, angle_ok)

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Brake angle from velocity testbench
// Drives axis/velocity requests with random gaps, stalls the result side at
// random, and predicts every brake angle from its own model of the lean
// angle, slew and limit. Configuration changes between phases while idle.
// ----------------------------------------------------------------------------
module tb_top;
	import bafv_pkg::*;

	localparam int IDLE_PCT = 7;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int TAIL_CYCLES = 30;
	localparam int LEAN_CAP = 36000;
	localparam int STEP_FLOOR = 4;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef struct {
		logic axis;
		logic signed [VEL_W-1:0] velocity;
	} vel_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic axis = 1'b0;
	logic signed [VEL_W-1:0] velocity = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic signed [ANG_W-1:0] angle;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	vel_req_t feed_q[$];
	vel_req_t next_req;
	logic signed [ANG_W-1:0] angle_q[$];
	logic signed [ANG_W-1:0] want_angle;
	logic item_held = 1'b0;
	int errors = 0;
	int cycle_count = 0;
	int idle_cycles = 0;
	logic quiet;

	logic [GAIN_W-1:0] gain_q;
	logic [RATE_W-1:0] rate_q;
	logic [LIM_W-1:0] limit_q;
	int axis_angle[NUM_AXES];

	brake_angle_from_velocity dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.axis(axis),
		.velocity(velocity),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.angle(angle),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	assign quiet = (cycle_count % 20000) >= 14000;

	function automatic logic signed [ANG_W-1:0] next_angle(input logic ax,
			input logic signed [VEL_W-1:0] vel);
		int v, idx, lean, step, lim, lo, hi, a;
		longint unsigned mag_v, num, den, mag;
		v = vel;
		idx = int'(ax) % NUM_AXES;
		mag_v = (v < 0) ? -v : v;
		num = 64'd4 * gain_q * mag_v * (mag_v + 64'd560);
		den = (mag_v + 64'd60) * 64'd65536;
		mag = (num + den / 2) / den;
		if (mag > LEAN_CAP)
			mag = LEAN_CAP;
		lean = (v >= 0) ? -int'(mag) : int'(mag);
		step = (rate_q < STEP_FLOOR) ? STEP_FLOOR : int'(rate_q);
		lim = int'(limit_q) * 4;
		if (lim > LEAN_CAP)
			lim = LEAN_CAP;
		lo = axis_angle[idx] - step;
		hi = axis_angle[idx] + step;
		if (lean < lo)
			a = lo;
		else if (lean > hi)
			a = hi;
		else
			a = lean;
		if (a < -lim)
			a = -lim;
		else if (a > lim)
			a = lim;
		axis_angle[idx] = a;
		return a[ANG_W-1:0];
	endfunction

	always @(posedge clk) begin
		if (arst_n && item_valid && !item_stall) begin
			angle_q.push_back(next_angle(axis, velocity));
			item_held = 1'b0;
		end
	end

	always @(negedge clk) begin
		if (arst_n && !item_held) begin
			if (feed_q.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
				next_req = feed_q.pop_front();
				item_valid <= 1'b1;
				axis <= next_req.axis;
				velocity <= next_req.velocity;
				item_held = 1'b1;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		result_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (angle_q.size() == 0) begin
				$display("%0t: angle %0d arrived with no request outstanding",
					$time, angle);
				errors++;
			end else begin
				want_angle = angle_q.pop_front();
				if (angle !== want_angle) begin
					$display("%0t: angle mismatch: expected %0d, actual %0d",
						$time, want_angle, angle);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic push_item(input logic ax, input int v);
		vel_req_t req;
		req.axis = ax;
		req.velocity = VEL_W'(v);
		feed_q.push_back(req);
	endtask

	task automatic gen_items(input int count, input int max_run);
		int n, len, base, v, k;
		logic ax;
		n = 0;
		while (n < count) begin
			if ($urandom_range(99) < 20) begin
				push_item(1'($urandom), int'($urandom_range(8191)) - 4096);
				n++;
			end else begin
				len = $urandom_range(max_run, 1);
				ax = 1'($urandom);
				case ($urandom_range(3))
					0: base = $urandom_range(100);
					1: base = $urandom_range(4000);
					2: base = $urandom_range(4000, 3500);
					default: base = $urandom_range(4096);
				endcase
				if ($urandom_range(1))
					base = -base;
				for (k = 0; k < len && n < count; k++) begin
					v = base + int'($urandom_range(40)) - 20;
					if (v > 4095)
						v = 4095;
					else if (v < -4096)
						v = -4096;
					push_item(ax, v);
					n++;
				end
			end
		end
	endtask

	task automatic wait_idle();
		while (feed_q.size() != 0 || item_held || angle_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_GAIN: gain_q = data[GAIN_W-1:0];
			CFG_RATE: rate_q = data[RATE_W-1:0];
			CFG_LIMIT: limit_q = data[LIM_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [CFG_DATA_W-1:0] gain,
			input logic [CFG_DATA_W-1:0] rate, input logic [CFG_DATA_W-1:0] limit);
		wait_idle();
		write_reg(CFG_GAIN, gain);
		write_reg(CFG_RATE, rate);
		write_reg(CFG_LIMIT, limit);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int p;
		gain_q = GAIN_RST;
		rate_q = RATE_RST;
		limit_q = LIMIT_RST;
		for (p = 0; p < NUM_AXES; p++)
			axis_angle[p] = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		push_item(1'b0, 0);
		push_item(1'b1, 0);
		push_item(1'b0, 1);
		push_item(1'b0, -1);
		push_item(1'b1, 60);
		push_item(1'b1, -60);
		push_item(1'b0, 500);
		push_item(1'b1, -500);
		push_item(1'b0, 4000);
		push_item(1'b0, 4000);
		push_item(1'b1, -4000);
		push_item(1'b1, -4000);
		push_item(1'b0, 4095);
		push_item(1'b1, -4096);
		push_item(1'b0, -4096);
		push_item(1'b1, 4095);
		gen_items(200, 40);

		set_config(16'hFFFF, 16'd127, 16'd16383);
		push_item(1'b0, 4095);
		push_item(1'b1, -4096);
		push_item(1'b0, 1);
		push_item(1'b1, -1);
		gen_items(250, 400);

		set_config(16'd0, 16'd0, 16'd0);
		gen_items(100, 40);

		set_config(16'($urandom), 16'd100, 16'd9000);
		gen_items(250, 120);

		wait_idle();
		write_reg(CFG_UNUSED, 16'hFFFF);
		set_config(16'd1, 16'd3, 16'd1);
		gen_items(100, 40);

		for (p = 0; p < 8; p++) begin
			set_config(16'($urandom), 16'($urandom), 16'($urandom));
			gen_items(120, 60);
		end

		wait_idle();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (errors == 0 && angle_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
